>>> src/zmvu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the Z-machine variable unit.
package zmvu_pkg;

	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 24;
	localparam int LOC_IDX_W   = 15;
	localparam int FIRST_GLOBAL = 16;

	localparam logic REG_GLOBALS_BASE = 1'b0;
	localparam logic REG_VERSION_SIX  = 1'b1;

	typedef enum logic [3:0] {
		OP_INC        = 4'd0,
		OP_DEC        = 4'd1,
		OP_INC_CHK    = 4'd2,
		OP_DEC_CHK    = 4'd3,
		OP_LOAD       = 4'd4,
		OP_STORE      = 4'd5,
		OP_PULL       = 4'd6,
		OP_PUSH       = 4'd7,
		OP_POP        = 4'd8,
		OP_POP_STACK  = 4'd9,
		OP_PUSH_STACK = 4'd10,
		OP_MEM_WRITE  = 4'd11
	} op_t;

	typedef enum logic [1:0] {
		VK_TOP    = 2'd0,
		VK_LOCAL  = 2'd1,
		VK_GLOBAL = 2'd2
	} vkind_t;

	typedef struct packed {
		op_t                  op;
		logic [15:0]          arg_first;
		logic [15:0]          arg_second;
		logic [3:0]           arg_count;
		vkind_t               kind;
		logic                 local_bad;
		logic [LOC_IDX_W-1:0] loc_idx;
		logic [15:0]          gaddr;
	} cmd_t;

	typedef struct packed {
		logic        fault;
		logic        branch_taken;
		logic        branch_valid;
		logic        store_valid;
		logic [15:0] result_value;
	} result_t;

endpackage

>>> src/zmvu_front.sv
`timescale 1ns / 1ps
// Front end: takes input beats, resolves the variable number and registers the command.
module zmvu_front #(
	parameter int STACK_WORDS = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [zmvu_pkg::IN_TDATA_W-1:0]    in_tdata,
	input  logic [15:0]                        globals_base,
	output logic                               cmd_valid,
	input  logic                               cmd_ready,
	output zmvu_pkg::cmd_t                     cmd
);
	import zmvu_pkg::*;

	logic        valid_s1;
	cmd_t        cmd_s1;
	cmd_t        cmd_d;
	logic [15:0] a1;
	logic [15:0] fp_ext;
	logic [15:0] var_ext;
	logic [15:0] diff;
	logic [15:0] gofs;

	always_comb begin
		a1      = in_tdata[19:4];
		fp_ext  = {5'b0, in_tdata[50:40]};
		var_ext = {12'b0, a1[3:0]};
		diff    = fp_ext - var_ext;
		gofs    = a1 - 16'(FIRST_GLOBAL);

		cmd_d.op         = op_t'(in_tdata[3:0]);
		cmd_d.arg_first  = a1;
		cmd_d.arg_second = in_tdata[35:20];
		cmd_d.arg_count  = in_tdata[39:36];
		if (a1 == 16'd0) begin
			cmd_d.kind = VK_TOP;
		end else if (a1 < 16'(FIRST_GLOBAL)) begin
			cmd_d.kind = VK_LOCAL;
		end else begin
			cmd_d.kind = VK_GLOBAL;
		end
		cmd_d.local_bad = (fp_ext < var_ext) || (diff >= 16'(STACK_WORDS));
		cmd_d.loc_idx   = diff[LOC_IDX_W-1:0];
		cmd_d.gaddr     = globals_base + {gofs[14:0], 1'b0};
	end

	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

>>> src/zmvu_queue.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the execution sequencer.
module zmvu_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  zmvu_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output zmvu_pkg::cmd_t pop_cmd
);
	import zmvu_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> src/zmvu_back.sv
`timescale 1ns / 1ps
// Execution sequencer: byte memory, word stack, stack pointer and result register.
module zmvu_back #(
	parameter int MEM_BYTES   = 65536,
	parameter int STACK_WORDS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  zmvu_pkg::cmd_t    cmd,
	input  logic              version_six,
	output logic              out_valid,
	input  logic              out_ready,
	output zmvu_pkg::result_t out
);
	import zmvu_pkg::*;

	localparam int MAW = $clog2(MEM_BYTES);
	localparam int SIW = $clog2(STACK_WORDS);
	localparam int SPW = $clog2(STACK_WORDS + 1);
	localparam logic [63:0] MEM_RECIP =
		((64'd1 << 32) + 64'(MEM_BYTES) - 64'd1) / 64'(MEM_BYTES);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_PREP = 9'b000000010,
		S_RA   = 9'b000000100,
		S_RB   = 9'b000001000,
		S_RC   = 9'b000010000,
		S_EXEC = 9'b000100000,
		S_WA   = 9'b001000000,
		S_WB   = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t         state_q;
	cmd_t           cmd_q;
	result_t        res_q;
	result_t        out_q;
	logic           out_valid_q;
	logic [SPW-1:0] sp_q;
	logic [15:0]    addr_q;
	logic [SIW-1:0] sidx_q;
	logic           src_stack_q;
	logic           byte_q;
	logic           pend_rd_q;
	logic           w2_pend_q;
	logic           rd2_pend_q;
	logic           phase2_q;
	logic [15:0]    w2_addr_q;
	logic [15:0]    w2_val_q;
	logic [15:0]    wval_q;
	logic [15:0]    rv_q;
	logic [7:0]     hi_q;
	logic [7:0]     q_hi_q;
	logic [7:0]     q_lo_q;

	logic [7:0]     mem [MEM_BYTES];
	logic [15:0]    stk [STACK_WORDS];
	logic [7:0]     mem_rdata_q;
	logic [15:0]    stk_rdata_q;

	logic           mem_we;
	logic [MAW-1:0] mem_waddr;
	logic [7:0]     mem_wdata;
	logic [MAW-1:0] mem_raddr;
	logic           stk_we;
	logic [MAW-1:0] idx_hi;
	logic [MAW-1:0] idx_lo;
	logic [15:0]    addr_lo;

	logic           sp_empty;
	logic [SPW-1:0] sp_inc;
	logic [SPW-1:0] sp_dec;
	logic [16:0]    sp_sum;
	logic           var_fault;
	logic           out_free;
	logic           wr_done;
	logic [15:0]    nv;
	logic [15:0]    size_inc;
	logic [15:0]    size_dec;

	function automatic logic [7:0] quot(input logic [15:0] a);
		logic [40:0] prod;
		prod = 41'(a) * 41'(MEM_RECIP[24:0]);
		return prod[39:32];
	endfunction

	function automatic logic [MAW-1:0] reduce(input logic [15:0] a, input logic [7:0] q);
		logic [23:0] r;
		r = 24'(a) - 24'(q) * 24'(MEM_BYTES);
		return r[MAW-1:0];
	endfunction

	// The quotient for the address is registered, so addr_q settles in S_PREP.
	always_ff @(posedge clk) begin
		q_hi_q <= quot(addr_q);
		q_lo_q <= quot(addr_lo);
	end

	always_comb begin
		addr_lo   = addr_q + 16'd1;
		idx_hi    = reduce(addr_q, q_hi_q);
		idx_lo    = reduce(addr_lo, q_lo_q);
		mem_raddr = (state_q == S_RB) ? idx_lo : idx_hi;
		mem_we    = 1'b0;
		mem_waddr = idx_hi;
		mem_wdata = byte_q ? wval_q[7:0] : wval_q[15:8];
		stk_we    = 1'b0;
		if (state_q == S_WA) begin
			if (src_stack_q) begin
				stk_we = 1'b1;
			end else begin
				mem_we = 1'b1;
			end
		end else if (state_q == S_WB) begin
			mem_we    = 1'b1;
			mem_waddr = idx_lo;
			mem_wdata = wval_q[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk[sidx_q] <= wval_q;
		stk_rdata_q <= stk[sidx_q];
	end

	always_comb begin
		sp_empty  = sp_q == SPW'(STACK_WORDS);
		sp_inc    = sp_q + SPW'(1);
		sp_dec    = sp_q - SPW'(1);
		sp_sum    = 17'(sp_q) + 17'(cmd.arg_first);
		var_fault = ((cmd.kind == VK_TOP) && sp_empty) ||
			((cmd.kind == VK_LOCAL) && cmd.local_bad);
		out_free  = !out_valid_q || out_ready;
		wr_done   = ((state_q == S_WA) && (src_stack_q || byte_q)) || (state_q == S_WB);
		nv        = ((cmd_q.op == OP_INC) || (cmd_q.op == OP_INC_CHK)) ?
			rv_q + 16'd1 : rv_q - 16'd1;
		size_inc  = rv_q + 16'd1;
		size_dec  = rv_q - 16'd1;
	end

	assign cmd_ready = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= SPW'(STACK_WORDS);
			out_valid_q <= 1'b0;
			w2_pend_q   <= 1'b0;
			rd2_pend_q  <= 1'b0;
			phase2_q    <= 1'b0;
			pend_rd_q   <= 1'b0;
			byte_q      <= 1'b0;
			src_stack_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
				out_q       <= res_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q      <= cmd;
						res_q      <= '0;
						byte_q     <= 1'b0;
						w2_pend_q  <= 1'b0;
						rd2_pend_q <= 1'b0;
						phase2_q   <= 1'b0;
						pend_rd_q  <= 1'b1;
						src_stack_q <= cmd.kind != VK_GLOBAL;
						sidx_q     <= (cmd.kind == VK_LOCAL) ?
							cmd.loc_idx[SIW-1:0] : sp_q[SIW-1:0];
						addr_q     <= cmd.gaddr;
						priority case (cmd.op)
							OP_INC, OP_DEC, OP_INC_CHK, OP_DEC_CHK, OP_LOAD: begin
								if (var_fault) begin
									res_q.fault <= 1'b1;
									state_q     <= S_DONE;
								end else begin
									state_q <= (cmd.kind == VK_GLOBAL) ? S_PREP : S_RA;
								end
							end
							OP_STORE: begin
								if (var_fault) begin
									res_q.fault <= 1'b1;
									state_q     <= S_DONE;
								end else begin
									state_q <= S_EXEC;
								end
							end
							OP_PULL: begin
								if (version_six && cmd.arg_count == 4'd1) begin
									addr_q      <= cmd.arg_first;
									src_stack_q <= 1'b0;
									state_q     <= S_PREP;
								end else if (sp_empty) begin
									res_q.fault <= 1'b1;
									state_q     <= S_DONE;
								end else begin
									src_stack_q <= 1'b1;
									sidx_q      <= sp_q[SIW-1:0];
									state_q     <= S_RA;
								end
							end
							OP_PUSH: begin
								if (sp_q == '0) begin
									res_q.fault <= 1'b1;
									state_q     <= S_DONE;
								end else begin
									sp_q        <= sp_dec;
									sidx_q      <= sp_dec[SIW-1:0];
									wval_q      <= cmd.arg_first;
									src_stack_q <= 1'b1;
									state_q     <= S_WA;
								end
							end
							OP_POP: begin
								if (sp_empty) begin
									res_q.fault <= 1'b1;
								end else begin
									sp_q <= sp_inc;
								end
								state_q <= S_DONE;
							end
							OP_POP_STACK: begin
								if (cmd.arg_count == 4'd2) begin
									addr_q      <= cmd.arg_second;
									src_stack_q <= 1'b0;
									state_q     <= S_PREP;
								end else begin
									if (sp_sum > 17'(STACK_WORDS)) begin
										res_q.fault <= 1'b1;
									end else begin
										sp_q <= sp_sum[SPW-1:0];
									end
									state_q <= S_DONE;
								end
							end
							OP_PUSH_STACK: begin
								addr_q      <= cmd.arg_second;
								src_stack_q <= 1'b0;
								state_q     <= S_PREP;
							end
							OP_MEM_WRITE: begin
								addr_q      <= cmd.arg_first;
								wval_q      <= cmd.arg_second;
								byte_q      <= 1'b1;
								src_stack_q <= 1'b0;
								pend_rd_q   <= 1'b0;
								state_q     <= S_PREP;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_PREP: state_q <= pend_rd_q ? S_RA : S_WA;
				S_RA:   state_q <= S_RB;
				S_RB: begin
					hi_q    <= mem_rdata_q;
					state_q <= S_RC;
				end
				S_RC: begin
					rv_q    <= src_stack_q ? stk_rdata_q : {hi_q, mem_rdata_q};
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					pend_rd_q <= 1'b0;
					priority case (cmd_q.op)
						OP_INC, OP_DEC, OP_INC_CHK, OP_DEC_CHK: begin
							wval_q <= nv;
							if (cmd_q.op == OP_INC_CHK) begin
								res_q.branch_valid <= 1'b1;
								res_q.branch_taken <= $signed(nv) > $signed(cmd_q.arg_second);
							end else if (cmd_q.op == OP_DEC_CHK) begin
								res_q.branch_valid <= 1'b1;
								res_q.branch_taken <= $signed(nv) < $signed(cmd_q.arg_second);
							end
							state_q <= src_stack_q ? S_WA : S_PREP;
						end
						OP_LOAD: begin
							res_q.result_value <= rv_q;
							res_q.store_valid  <= 1'b1;
							state_q            <= S_DONE;
						end
						OP_STORE: begin
							wval_q  <= cmd_q.arg_second;
							state_q <= src_stack_q ? S_WA : S_PREP;
						end
						OP_PULL: begin
							if (phase2_q) begin
								res_q.result_value <= rv_q;
								res_q.store_valid  <= 1'b1;
								state_q            <= S_DONE;
							end else if (version_six && cmd_q.arg_count == 4'd1) begin
								// Bump the size word, then fetch the slot it now names.
								wval_q     <= size_inc;
								rd2_pend_q <= 1'b1;
								w2_addr_q  <= cmd_q.arg_first + {size_inc[14:0], 1'b0};
								state_q    <= S_PREP;
							end else if (version_six) begin
								sp_q               <= sp_inc;
								res_q.result_value <= rv_q;
								res_q.store_valid  <= 1'b1;
								state_q            <= S_DONE;
							end else if (cmd_q.arg_first == 16'd0) begin
								if (sp_inc == SPW'(STACK_WORDS)) begin
									res_q.fault <= 1'b1;
									state_q     <= S_DONE;
								end else begin
									sp_q        <= sp_inc;
									sidx_q      <= sp_inc[SIW-1:0];
									wval_q      <= rv_q;
									src_stack_q <= 1'b1;
									state_q     <= S_WA;
								end
							end else if (cmd_q.kind == VK_LOCAL && cmd_q.local_bad) begin
								res_q.fault <= 1'b1;
								state_q     <= S_DONE;
							end else begin
								sp_q   <= sp_inc;
								wval_q <= rv_q;
								if (cmd_q.kind == VK_LOCAL) begin
									src_stack_q <= 1'b1;
									sidx_q      <= cmd_q.loc_idx[SIW-1:0];
									state_q     <= S_WA;
								end else begin
									src_stack_q <= 1'b0;
									addr_q      <= cmd_q.gaddr;
									state_q     <= S_PREP;
								end
							end
						end
						OP_POP_STACK: begin
							wval_q  <= rv_q + cmd_q.arg_first;
							state_q <= S_PREP;
						end
						OP_PUSH_STACK: begin
							res_q.branch_valid <= 1'b1;
							if (rv_q != 16'd0) begin
								addr_q             <= cmd_q.arg_second + {rv_q[14:0], 1'b0};
								wval_q             <= cmd_q.arg_first;
								w2_pend_q          <= 1'b1;
								w2_addr_q          <= cmd_q.arg_second;
								w2_val_q           <= size_dec;
								res_q.branch_taken <= size_dec != 16'd0;
								state_q            <= S_PREP;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_WA: begin
					if (!(src_stack_q || byte_q)) state_q <= S_WB;
				end
				S_WB: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			// Chain the second word write or the dependent read, else finish.
			if (wr_done) begin
				if (w2_pend_q) begin
					addr_q      <= w2_addr_q;
					wval_q      <= w2_val_q;
					w2_pend_q   <= 1'b0;
					src_stack_q <= 1'b0;
					pend_rd_q   <= 1'b0;
					state_q     <= S_PREP;
				end else if (rd2_pend_q) begin
					addr_q      <= w2_addr_q;
					rd2_pend_q  <= 1'b0;
					phase2_q    <= 1'b1;
					src_stack_q <= 1'b0;
					pend_rd_q   <= 1'b1;
					state_q     <= S_PREP;
				end else begin
					state_q <= S_DONE;
				end
			end
		end
	end

endmodule

>>> src/zmachine_variable_unit.sv
`timescale 1ns / 1ps
// Top level of the Z-machine variable unit: stream ports, APB registers, front, queue, back.
//
// One instruction per input beat, one result beat per instruction, in order. The execution
// sequencer takes one instruction at a time; its steps are set by the byte memory, which moves
// one byte per cycle and passes through S_PREP for each new address. The front register and
// a two-entry queue accept further beats while the sequencer works. Memory and stack contents
// are undefined after reset; the stack pointer and the APB registers are cleared.
module zmachine_variable_unit #(
	parameter int MEM_BYTES   = 65536,
	parameter int STACK_WORDS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// opcode[3:0], arg_first[19:4], arg_second[35:20], arg_count[39:36], frame_index[50:40]
	input  logic [zmvu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// result_value[15:0], store_valid[16], branch_valid[17], branch_taken[18], fault[19]
	output logic [zmvu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import zmvu_pkg::*;

	logic [15:0] globals_base_q;
	logic        version_six_q;
	logic        fq_valid;
	logic        fq_ready;
	cmd_t        fq_cmd;
	logic        qb_valid;
	logic        qb_ready;
	cmd_t        qb_cmd;
	result_t     res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			globals_base_q <= 16'd0;
			version_six_q  <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_GLOBALS_BASE: globals_base_q <= pwdata[15:0];
				REG_VERSION_SIX:  version_six_q  <= pwdata[0];
				default:          version_six_q  <= version_six_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_GLOBALS_BASE: prdata = {16'd0, globals_base_q};
			REG_VERSION_SIX:  prdata = {31'd0, version_six_q};
			default:          prdata = 32'd0;
		endcase
	end

	zmvu_front #(
		.STACK_WORDS(STACK_WORDS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_tdata     (s_axis_tdata),
		.globals_base (globals_base_q),
		.cmd_valid    (fq_valid),
		.cmd_ready    (fq_ready),
		.cmd          (fq_cmd)
	);

	zmvu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cmd   (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_cmd    (qb_cmd)
	);

	zmvu_back #(
		.MEM_BYTES   (MEM_BYTES),
		.STACK_WORDS (STACK_WORDS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (qb_valid),
		.cmd_ready   (qb_ready),
		.cmd         (qb_cmd),
		.version_six (version_six_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out         (res)
	);

	assign m_axis_tdata = {4'd0, res};

endmodule

>>> src/zmvu_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the Z-machine variable unit, bound to the top level.
module zmvu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);
	logic [3:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// Track instructions taken but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 4'd0;
		end else begin
			pending_q <= pending_q + {3'd0, in_beat} - {3'd0, out_beat};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != 4'd0)
		else $error("result beat without an outstanding instruction");

	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[19] |-> m_axis_tdata[18:0] == 19'd0)
		else $error("faulting result carries other fields");

endmodule

bind zmachine_variable_unit zmvu_checker u_zmvu_checker (.*);

>>> tb/tb_zmachine_variable_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Z-machine variable unit: directed table, then random stream.
module tb_zmachine_variable_unit;
	import zmvu_pkg::*;

	localparam int SW        = 1024;
	localparam int SETTLE    = 40;
	localparam int MAX_CYC   = 2000000;
	localparam int HOLD_LEN  = 300;

	typedef struct packed {
		logic [3:0]  op;
		logic [15:0] a1;
		logic [15:0] a2;
		logic [3:0]  argc;
		logic [10:0] fp;
	} instr_t;

	typedef struct {
		instr_t  it;
		bit      typed;
		result_t want;
	} row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// opcode[3:0], arg_first[19:4], arg_second[35:20], arg_count[39:36], frame_index[50:40]
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// result_value[15:0], store_valid[16], branch_valid[17], branch_taken[18], fault[19]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [2:0]             paddr = '0;
	logic [31:0]            pwdata = '0;
	logic [31:0]            prdata;
	logic                   pready;

	zmachine_variable_unit dut (.*);

	always #5 clk = ~clk;

	// Shadow machine state
	logic [7:0]  mem_img [65536];
	bit          mem_ok  [65536];
	logic [15:0] stack_img [SW];
	bit          stack_ok  [SW];
	int          stack_ptr = SW;
	logic [15:0] gbase = '0;
	bit          v6 = 1'b0;

	result_t pending_results[$];
	int      errs = 0;
	int      cycles = 0;
	int      snd_idle = 0;
	int      rcv_idle = 0;
	int      hold_req = 0;

	function automatic logic [15:0] read_word(input logic [15:0] a);
		return {mem_img[a], mem_img[16'(a + 16'd1)]};
	endfunction

	function automatic void write_word(input logic [15:0] a, input logic [15:0] v);
		mem_img[a] = v[15:8];
		mem_ok[a] = 1'b1;
		mem_img[16'(a + 16'd1)] = v[7:0];
		mem_ok[16'(a + 16'd1)] = 1'b1;
	endfunction

	// Returns -1 on a stack fault, else a vkind_t code; where is stack index or byte address.
	function automatic int resolve_var(input logic [15:0] n, input logic [10:0] fp,
			output int where);
		where = 0;
		if (n == 0) begin
			if (stack_ptr >= SW) return -1;
			where = stack_ptr;
			return VK_TOP;
		end
		if (n < FIRST_GLOBAL) begin
			if (fp < n || fp - n >= SW) return -1;
			where = fp - n;
			return VK_LOCAL;
		end
		where = 16'(gbase + 2 * (n - FIRST_GLOBAL));
		return VK_GLOBAL;
	endfunction

	function automatic logic [15:0] read_var(input int k, input int where);
		if (k == VK_GLOBAL) return read_word(16'(where));
		return stack_img[where];
	endfunction

	function automatic void write_var(input int k, input int where, input logic [15:0] v);
		if (k == VK_GLOBAL) write_word(16'(where), v);
		else begin
			stack_img[where] = v;
			stack_ok[where] = 1'b1;
		end
	endfunction

	function automatic result_t execute_instr(input instr_t it);
		result_t r;
		int k;
		int w;
		logic [15:0] v;
		logic [15:0] sz;
		r = '0;
		case (it.op)
			OP_INC, OP_DEC, OP_INC_CHK, OP_DEC_CHK: begin
				k = resolve_var(it.a1, it.fp, w);
				if (k < 0) r.fault = 1'b1;
				else begin
					v = read_var(k, w);
					v = (it.op == OP_INC || it.op == OP_INC_CHK) ? v + 16'd1 : v - 16'd1;
					write_var(k, w, v);
					if (it.op == OP_INC_CHK) begin
						r.branch_valid = 1'b1;
						r.branch_taken = $signed(v) > $signed(it.a2);
					end
					if (it.op == OP_DEC_CHK) begin
						r.branch_valid = 1'b1;
						r.branch_taken = $signed(v) < $signed(it.a2);
					end
				end
			end
			OP_LOAD: begin
				k = resolve_var(it.a1, it.fp, w);
				if (k < 0) r.fault = 1'b1;
				else begin
					r.result_value = read_var(k, w);
					r.store_valid = 1'b1;
				end
			end
			OP_STORE: begin
				k = resolve_var(it.a1, it.fp, w);
				if (k < 0) r.fault = 1'b1;
				else write_var(k, w, it.a2);
			end
			OP_PULL: begin
				if (v6 && it.argc == 1) begin
					sz = read_word(it.a1) + 16'd1;
					write_word(it.a1, sz);
					r.result_value = read_word(16'(it.a1 + 2 * sz));
					r.store_valid = 1'b1;
				end else if (stack_ptr >= SW) r.fault = 1'b1;
				else begin
					v = stack_img[stack_ptr];
					if (v6) begin
						stack_ptr++;
						r.result_value = v;
						r.store_valid = 1'b1;
					end else if (it.a1 == 0) begin
						if (stack_ptr + 1 >= SW) r.fault = 1'b1;
						else begin
							stack_ptr++;
							stack_img[stack_ptr] = v;
						end
					end else begin
						k = resolve_var(it.a1, it.fp, w);
						if (k < 0) r.fault = 1'b1;
						else begin
							stack_ptr++;
							write_var(k, w, v);
						end
					end
				end
			end
			OP_PUSH: begin
				if (stack_ptr == 0) r.fault = 1'b1;
				else begin
					stack_ptr--;
					stack_img[stack_ptr] = it.a1;
					stack_ok[stack_ptr] = 1'b1;
				end
			end
			OP_POP: begin
				if (stack_ptr >= SW) r.fault = 1'b1;
				else stack_ptr++;
			end
			OP_POP_STACK: begin
				if (it.argc == 2) write_word(it.a2, read_word(it.a2) + it.a1);
				else if (stack_ptr + it.a1 > SW) r.fault = 1'b1;
				else stack_ptr += it.a1;
			end
			OP_PUSH_STACK: begin
				sz = read_word(it.a2);
				if (sz != 0) begin
					write_word(16'(it.a2 + 2 * sz), it.a1);
					sz--;
					write_word(it.a2, sz);
				end
				r.branch_valid = 1'b1;
				r.branch_taken = sz != 0;
			end
			OP_MEM_WRITE: begin
				mem_img[it.a1] = it.a2[7:0];
				mem_ok[it.a1] = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Find a read of storage never written; return the beat that fills it first.
	function automatic bit find_gap(input instr_t it, output instr_t fill);
		int k;
		int w;
		logic [15:0] sz;
		logic [15:0] t;
		fill = '{op: OP_MEM_WRITE, a1: '0, a2: 16'($urandom), argc: 4'd2, fp: '0};
		case (it.op)
			OP_INC, OP_DEC, OP_INC_CHK, OP_DEC_CHK, OP_LOAD: begin
				k = resolve_var(it.a1, it.fp, w);
				if (k == VK_GLOBAL) begin
					fill.a1 = 16'(w);
					if (!mem_ok[fill.a1]) return 1'b1;
					fill.a1 = 16'(w + 1);
					if (!mem_ok[fill.a1]) return 1'b1;
				end else if (k >= 0 && !stack_ok[w]) begin
					fill = '{op: OP_STORE, a1: it.a1, a2: 16'($urandom), argc: 4'd2,
						fp: it.fp};
					return 1'b1;
				end
			end
			OP_PULL: begin
				if (v6 && it.argc == 1) begin
					fill.a1 = it.a1;
					if (!mem_ok[fill.a1]) return 1'b1;
					fill.a1 = 16'(it.a1 + 1);
					if (!mem_ok[fill.a1]) return 1'b1;
					sz = read_word(it.a1) + 16'd1;
					for (int i = 0; i < 2; i++) begin
						t = 16'(it.a1 + 2 * sz + i);
						if (!mem_ok[t] && t != it.a1 && t != 16'(it.a1 + 1)) begin
							fill.a1 = t;
							return 1'b1;
						end
					end
				end
			end
			OP_POP_STACK, OP_PUSH_STACK: begin
				if (it.op == OP_PUSH_STACK || it.argc == 2) begin
					fill.a1 = it.a2;
					if (!mem_ok[fill.a1]) return 1'b1;
					fill.a1 = 16'(it.a2 + 1);
					if (!mem_ok[fill.a1]) return 1'b1;
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic logic [15:0] rand_var();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 15) return 16'd0;
		if (sel < 50) return 16'($urandom_range(1, 15));
		if (sel < 85) return 16'($urandom_range(16, 47));
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] rand_ustack();
		case ($urandom_range(0, 3))
			0: return 16'h0200;
			1: return 16'h0400;
			2: return 16'hFFFE;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic instr_t rand_instr();
		instr_t it;
		int sel;
		it.a1 = rand_var();
		it.a2 = 16'($urandom);
		sel = $urandom_range(0, 9);
		it.argc = (sel < 4) ? 4'd1 : (sel < 8) ? 4'd2 : 4'($urandom);
		if ($urandom_range(0, 9) == 0) it.fp = 11'($urandom);
		else it.fp = 11'($urandom_range(stack_ptr, stack_ptr + 15 > SW ? SW : stack_ptr + 15));
		sel = $urandom_range(0, 99);
		if (sel < 8) it.op = OP_INC;
		else if (sel < 16) it.op = OP_DEC;
		else if (sel < 24) it.op = OP_INC_CHK;
		else if (sel < 32) it.op = OP_DEC_CHK;
		else if (sel < 42) it.op = OP_LOAD;
		else if (sel < 52) it.op = OP_STORE;
		else if (sel < 60) it.op = OP_PULL;
		else if (sel < 74) it.op = OP_PUSH;
		else if (sel < 80) it.op = OP_POP;
		else if (sel < 86) it.op = OP_POP_STACK;
		else if (sel < 92) it.op = OP_PUSH_STACK;
		else if (sel < 97) it.op = OP_MEM_WRITE;
		else it.op = 4'($urandom_range(12, 15));
		case (it.op)
			OP_PUSH: it.a1 = 16'($urandom);
			OP_PULL: if (v6 && it.argc == 1) it.a1 = rand_ustack();
			OP_POP_STACK: begin
				if (it.argc == 2) it.a2 = rand_ustack();
				it.a1 = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
			end
			OP_PUSH_STACK: begin
				it.a1 = 16'($urandom);
				it.a2 = rand_ustack();
			end
			OP_MEM_WRITE: it.a1 = 16'($urandom);
			default: ;
		endcase
		return it;
	endfunction

	// Offer one beat; predict on acceptance.
	task automatic send_beat(input instr_t it, input bit typed, input result_t want);
		result_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {5'd0, it.fp, it.argc, it.a2, it.a1, it.op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		r = execute_instr(it);
		pending_results.push_back(typed ? want : r);
	endtask

	task automatic send_clean(input instr_t it);
		instr_t fill;
		while (find_gap(it, fill)) send_beat(fill, 1'b0, '0);
		send_beat(it, 1'b0, '0);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input logic reg_idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {1'b0, reg_idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (reg_idx == REG_GLOBALS_BASE) gbase = val[15:0];
		else v6 = val[0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic run_random(input int count);
		repeat (count) send_clean(rand_instr());
	endtask

	// Receiver: random backpressure plus long hold-offs on request.
	initial begin
		int served;
		int hold_left;
		served = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req != served) begin
				served = hold_req;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready = 1'b0;
			end else m_axis_tready = $urandom_range(0, 99) >= rcv_idle;
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[19:0];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %h", $time, got);
				errs++;
			end else begin
				want = pending_results.pop_front();
				if (got.result_value !== want.result_value) begin
					$display("%0t: result_value expected %h actual %h", $time,
						want.result_value, got.result_value);
					errs++;
				end
				if (got.store_valid !== want.store_valid) begin
					$display("%0t: store_valid expected %b actual %b", $time,
						want.store_valid, got.store_valid);
					errs++;
				end
				if (got.branch_valid !== want.branch_valid) begin
					$display("%0t: branch_valid expected %b actual %b", $time,
						want.branch_valid, got.branch_valid);
					errs++;
				end
				if (got.branch_taken !== want.branch_taken) begin
					$display("%0t: branch_taken expected %b actual %b", $time,
						want.branch_taken, got.branch_taken);
					errs++;
				end
				if (got.fault !== want.fault) begin
					$display("%0t: fault expected %b actual %b", $time, want.fault, got.fault);
					errs++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYC) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		row_t dir_rows[$];
		dir_rows = '{
			'{'{OP_POP,        16'h0000, 16'h0000, 4'd0, 11'd0},    1'b1, 20'h80000},
			'{'{OP_LOAD,       16'h0000, 16'h0000, 4'd1, 11'd0},    1'b1, 20'h80000},
			'{'{OP_PULL,       16'h0000, 16'h0000, 4'd1, 11'd0},    1'b1, 20'h80000},
			'{'{OP_PUSH,       16'hFFFF, 16'hFFFF, 4'd1, 11'd0},    1'b1, 20'h00000},
			'{'{OP_PUSH,       16'h0000, 16'h0000, 4'd1, 11'd0},    1'b1, 20'h00000},
			'{'{OP_INC,        16'h0000, 16'h0000, 4'd1, 11'd0},    1'b0, 20'h00000},
			'{'{OP_DEC_CHK,    16'h0000, 16'h7FFF, 4'd2, 11'd0},    1'b1, 20'h60000},
			'{'{OP_STORE,      16'h0001, 16'h8000, 4'd2, 11'd1024}, 1'b0, 20'h00000},
			'{'{OP_INC_CHK,    16'h0001, 16'h7FFF, 4'd2, 11'd1024}, 1'b1, 20'h20000},
			'{'{OP_LOAD,       16'h000F, 16'h0000, 4'd1, 11'd0},    1'b1, 20'h80000},
			'{'{OP_STORE,      16'h0001, 16'h1111, 4'd2, 11'd2047}, 1'b1, 20'h80000},
			'{'{OP_MEM_WRITE,  16'h0000, 16'hFF12, 4'd2, 11'd0},    1'b0, 20'h00000},
			'{'{OP_MEM_WRITE,  16'h0001, 16'h0034, 4'd2, 11'd0},    1'b0, 20'h00000},
			'{'{OP_LOAD,       16'h0010, 16'h0000, 4'd1, 11'd0},    1'b1, 20'h11234},
			'{'{OP_MEM_WRITE,  16'hFFFF, 16'h00AB, 4'd2, 11'd0},    1'b0, 20'h00000},
			'{'{OP_POP_STACK,  16'hFFFF, 16'h0000, 4'd1, 11'd0},    1'b1, 20'h80000},
			'{'{OP_PUSH_STACK, 16'hBEEF, 16'h0000, 4'd2, 11'd0},    1'b1, 20'h60000},
			'{'{OP_POP_STACK,  16'h0001, 16'h0000, 4'd2, 11'd0},    1'b0, 20'h00000},
			'{'{OP_PULL,       16'h0000, 16'h0000, 4'd1, 11'd0},    1'b0, 20'h00000},
			'{'{OP_PULL,       16'h0000, 16'h0000, 4'd1, 11'd0},    1'b1, 20'h80000},
			'{'{4'd15,         16'hFFFF, 16'hFFFF, 4'd15, 11'd2047}, 1'b1, 20'h00000},
			'{'{OP_DEC,        16'h0010, 16'h0000, 4'd1, 11'd0},    1'b0, 20'h00000},
			'{'{OP_MEM_WRITE,  16'h0100, 16'h0000, 4'd2, 11'd0},    1'b0, 20'h00000},
			'{'{OP_MEM_WRITE,  16'h0101, 16'h0000, 4'd2, 11'd0},    1'b0, 20'h00000},
			'{'{OP_PUSH_STACK, 16'h5555, 16'h0100, 4'd2, 11'd0},    1'b1, 20'h20000}
		};
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		reg_write(REG_GLOBALS_BASE, 32'h0000_0000);
		reg_write(REG_VERSION_SIX, 32'h0);
		foreach (dir_rows[i]) send_beat(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		drain();

		// Sender mostly busy, receiver starved, with one long hold-off.
		snd_idle = 20;
		rcv_idle = 66;
		reg_write(REG_GLOBALS_BASE, 32'h0000_FFFF);
		reg_write(REG_VERSION_SIX, 32'h1);
		hold_req++;
		run_random(600);
		drain();

		snd_idle = 66;
		rcv_idle = 20;
		reg_write(REG_GLOBALS_BASE, 32'h0000_0200);
		reg_write(REG_VERSION_SIX, 32'h0);
		run_random(600);
		drain();

		snd_idle = 0;
		rcv_idle = 0;
		reg_write(REG_GLOBALS_BASE, 32'($urandom_range(0, 65535)));
		reg_write(REG_VERSION_SIX, 32'h1);
		// Fill the stack to overflow, then empty it in one go.
		while (stack_ptr != 0)
			send_beat('{OP_PUSH, 16'($urandom), 16'h0, 4'd1, 11'd0}, 1'b0, '0);
		send_beat('{OP_PUSH, 16'h1234, 16'h0, 4'd1, 11'd0}, 1'b0, '0);
		send_beat('{OP_POP_STACK, 16'hFFFF, 16'h0, 4'd1, 11'd0}, 1'b0, '0);
		send_clean('{OP_LOAD, 16'h0000, 16'h0, 4'd1, 11'd0});
		send_beat('{OP_POP_STACK, 16'd1024, 16'h0, 4'd0, 11'd0}, 1'b0, '0);
		run_random(600);
		drain();

		if (errs == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
